@@ rtl/core/spts_pkg.sv @@
package spts_pkg;

	localparam int CHANNELS     = 8;
	localparam int COUNT_WIDTH  = 24;
	localparam int SUM_W        = 26;
	localparam int POS_W        = 16;
	localparam int FRAC_W       = 16;
	localparam int CMD_CH_W     = 3;
	localparam int SLOT_FIELD_W = 5;
	localparam int CFG_IDX_W    = 3;

	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int LAST_SLOT = 2 * CHANNELS + 1;
	localparam int SLOT_W    = $clog2(LAST_SLOT + 1);
	localparam int CFG_W     = (COUNT_WIDTH > SUM_W) ? COUNT_WIDTH : SUM_W;
	localparam int ACC_W     = CFG_W + 1;
	localparam int PROD_W    = COUNT_WIDTH + 1 + POS_W;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	localparam int SLOT_SYNC      = 0;
	localparam int SLOT_SYNC_DROP = 2;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [SUM_W-1:0]       sum_t;
	typedef logic [SLOT_W-1:0]      slot_t;

	localparam count_t MIN_RESET    = COUNT_WIDTH'(33177);
	localparam count_t MAX_RESET    = COUNT_WIDTH'(66354);
	localparam count_t CENTER_RESET = COUNT_WIDTH'(49766);
	localparam sum_t   FRAME_RESET  = SUM_W'(1293916);
	localparam count_t COUNT_MAX    = '1;
	localparam sum_t   SUM_MAX      = '1;

	localparam logic [POS_W-1:0] POS_FULL_NEG = {1'b1, {(POS_W-1){1'b0}}};

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_SET  = 1'b1
	} command_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PULSE_MIN    = 3'd0,
		REG_PULSE_MAX    = 3'd1,
		REG_PULSE_CENTER = 3'd2,
		REG_FRAME_LENGTH = 3'd3,
		REG_SYNC_DISABLE = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic            en;
		logic [CH_W-1:0] addr;
		count_t          data;
	} store_wr_t;

	typedef struct packed {
		sum_t                    reload_count;
		logic                    sync_level;
		logic [SLOT_FIELD_W-1:0] slot;
		logic                    frame_end;
	} result_t;

endpackage

@@ rtl/core/spts_if.sv @@
interface spts_req_if;
	logic                              valid;
	logic                              ready;
	logic                              command;
	logic [spts_pkg::CMD_CH_W-1:0]     channel;
	logic signed [spts_pkg::POS_W-1:0] position;

	modport source (output valid, output command, output channel, output position, input ready);
	modport sink (input valid, input command, input channel, input position, output ready);
endinterface

interface spts_res_if;
	logic                                valid;
	logic                                ready;
	logic [spts_pkg::SUM_W-1:0]          reload_count;
	logic                                sync_level;
	logic [spts_pkg::SLOT_FIELD_W-1:0]   slot;
	logic                                frame_end;

	modport source (output valid, output reload_count, output sync_level, output slot,
		output frame_end, input ready);
	modport sink (input valid, input reload_count, input sync_level, input slot,
		input frame_end, output ready);
endinterface

@@ rtl/core/spts_chan_store.sv @@
module spts_chan_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [spts_pkg::CH_W-1:0]     rd_addr,
	input  spts_pkg::store_wr_t           wr,
	output spts_pkg::count_t              rd_data
);

	spts_pkg::count_t mem [spts_pkg::CHANNELS];
	spts_pkg::count_t mem_q;
	spts_pkg::count_t fwd_data_s1;
	logic [spts_pkg::CHANNELS-1:0] valid_q;
	logic ent_valid_s1;
	logic fwd_hit_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			mem_q       <= mem[rd_addr];
			fwd_data_s1 <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			ent_valid_s1 <= 1'b0;
			fwd_hit_s1   <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				ent_valid_s1 <= valid_q[rd_addr];
				fwd_hit_s1   <= wr.en && (wr.addr == rd_addr);
			end
		end
	end

	always_comb begin
		if (fwd_hit_s1) begin
			rd_data = fwd_data_s1;
		end else if (ent_valid_s1) begin
			rd_data = mem_q;
		end else begin
			rd_data = spts_pkg::CENTER_RESET;
		end
	end

endmodule

@@ rtl/core/servo_pulse_train_sequencer_core.sv @@
// Servo frame sequencer core.
// request carries two kinds of transaction. A set transaction (command 1)
// converts a signed Q1.15 position into a pulse count for one channel and
// yields no result. A tick transaction (command 0) closes one timer interval
// and yields exactly one result transaction: the reload count for the next
// interval, the sync pin level, the slot number and a frame-end flag.
// A frame runs over 2*CHANNELS+2 slots: a sync slot, two slots per channel,
// and a remainder slot.
// Throughput: one transaction per cycle while request.ready is high, with
// sets and ticks mixed freely. A tick's result passes through the stage-1
// registers and then the result buffer before it shows on result.
// The per-channel counts live in a one-port-read, one-port-write RAM with a
// registered read; a write-to-read forward covers back-to-back ticks and sets
// on the same channel.
// Results queue in a four-entry buffer; when result stalls, request.ready
// drops once the buffer plus the tick in flight would fill it.
// Reset: all channels read as the center count, slot 0, sync pin low,
// accumulated frame time zero, registers at their default values. Registers
// are written via wr_en/wr_index/wr_data only while idle; user-enforced.
module servo_pulse_train_sequencer_core (
	input  logic                             clk,
	input  logic                             arst_n,
	spts_req_if.sink                         request,
	spts_res_if.source                       result,
	input  logic                             wr_en,
	input  logic [spts_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [spts_pkg::CFG_W-1:0]       wr_data
);

	spts_pkg::count_t pulse_min_q;
	spts_pkg::count_t pulse_max_q;
	spts_pkg::count_t pulse_center_q;
	spts_pkg::sum_t   frame_length_q;
	logic             sync_disable_q;

	spts_pkg::slot_t  slot_q;
	spts_pkg::sum_t   elapsed_q;
	logic             sync_q;

	logic req_fire;
	logic req_set;
	logic req_tick;
	logic set_ok;
	spts_pkg::slot_t slot_m1;
	spts_pkg::slot_t slot_ch;
	logic [spts_pkg::CH_W-1:0] rd_addr;
	logic signed [spts_pkg::COUNT_WIDTH:0]  span;
	logic signed [spts_pkg::PROD_W-1:0]     prod_c;

	logic                               valid_s1;
	spts_pkg::command_t                 cmd_s1;
	spts_pkg::slot_t                    slot_s1;
	logic                               set_ok_s1;
	logic [spts_pkg::CH_W-1:0]          set_ch_s1;
	logic [spts_pkg::CH_W-1:0]          rd_ch_s1;
	logic signed [spts_pkg::PROD_W-1:0] prod_s1;
	logic                               full_neg_s1;

	spts_pkg::count_t rd_data;
	spts_pkg::store_wr_t store_wr;

	logic signed [spts_pkg::PROD_W-1:0]      prod_sh;
	logic signed [spts_pkg::COUNT_WIDTH:0]   q_c;
	logic signed [spts_pkg::COUNT_WIDTH+1:0] t_wide;
	spts_pkg::count_t set_sat;
	spts_pkg::count_t set_val;
	spts_pkg::count_t clamped;
	logic [spts_pkg::ACC_W-1:0] acc;
	spts_pkg::sum_t   acc_sat;
	spts_pkg::sum_t   remainder;
	logic s1_tick;
	logic s1_is_sync;
	logic s1_is_last;
	logic s1_is_chan;
	logic sync_next;
	spts_pkg::result_t res;

	spts_pkg::result_t fifo_q [spts_pkg::FIFO_DEPTH];
	logic [spts_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [spts_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [spts_pkg::FIFO_CW-1:0] cnt_q;
	logic push;
	logic pop;
	spts_pkg::result_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q    <= spts_pkg::MIN_RESET;
			pulse_max_q    <= spts_pkg::MAX_RESET;
			pulse_center_q <= spts_pkg::CENTER_RESET;
			frame_length_q <= spts_pkg::FRAME_RESET;
			sync_disable_q <= 1'b0;
		end else if (wr_en) begin
			unique case (spts_pkg::reg_index_t'(wr_index))
				spts_pkg::REG_PULSE_MIN:    pulse_min_q    <= wr_data[spts_pkg::COUNT_WIDTH-1:0];
				spts_pkg::REG_PULSE_MAX:    pulse_max_q    <= wr_data[spts_pkg::COUNT_WIDTH-1:0];
				spts_pkg::REG_PULSE_CENTER: pulse_center_q <= wr_data[spts_pkg::COUNT_WIDTH-1:0];
				spts_pkg::REG_FRAME_LENGTH: frame_length_q <= wr_data[spts_pkg::SUM_W-1:0];
				spts_pkg::REG_SYNC_DISABLE: sync_disable_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign req_fire = request.valid && request.ready;
	assign req_set  = spts_pkg::command_t'(request.command) == spts_pkg::CMD_SET;
	assign req_tick = req_fire && !req_set;
	assign set_ok   = 32'(request.channel) < spts_pkg::CHANNELS;

	assign slot_m1 = slot_q - spts_pkg::SLOT_W'(1);
	assign slot_ch = slot_m1 >> 1;
	assign rd_addr = (slot_ch >= spts_pkg::SLOT_W'(spts_pkg::CHANNELS))
		? spts_pkg::CH_W'(spts_pkg::CHANNELS - 1) : slot_ch[spts_pkg::CH_W-1:0];

	assign span   = signed'({1'b0, pulse_max_q}) - signed'({1'b0, pulse_min_q});
	assign prod_c = request.position * span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (req_tick) begin
			slot_q <= (slot_q == spts_pkg::SLOT_W'(spts_pkg::LAST_SLOT))
				? '0 : slot_q + spts_pkg::SLOT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1      <= spts_pkg::command_t'(request.command);
			slot_s1     <= slot_q;
			set_ok_s1   <= set_ok;
			set_ch_s1   <= spts_pkg::CH_W'(request.channel);
			rd_ch_s1    <= rd_addr;
			prod_s1     <= prod_c;
			full_neg_s1 <= request.position == spts_pkg::POS_FULL_NEG;
		end
	end

	spts_chan_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (req_tick),
		.rd_addr (rd_addr),
		.wr      (store_wr),
		.rd_data (rd_data)
	);

	assign prod_sh = prod_s1 >>> spts_pkg::FRAC_W;
	assign q_c     = prod_sh[spts_pkg::COUNT_WIDTH:0];
	assign t_wide  = signed'({2'b00, pulse_center_q}) + (spts_pkg::COUNT_WIDTH+2)'(q_c);

	always_comb begin
		if (t_wide[spts_pkg::COUNT_WIDTH+1]) begin
			set_sat = '0;
		end else if (t_wide[spts_pkg::COUNT_WIDTH]) begin
			set_sat = spts_pkg::COUNT_MAX;
		end else begin
			set_sat = t_wide[spts_pkg::COUNT_WIDTH-1:0];
		end
	end

	assign set_val = full_neg_s1 ? pulse_min_q : set_sat;

	always_comb begin
		if (rd_data < pulse_min_q) begin
			clamped = pulse_min_q;
		end else if (rd_data > pulse_max_q) begin
			clamped = pulse_max_q;
		end else begin
			clamped = rd_data;
		end
	end

	assign s1_tick    = valid_s1 && (cmd_s1 == spts_pkg::CMD_TICK);
	assign s1_is_sync = slot_s1 == spts_pkg::SLOT_W'(spts_pkg::SLOT_SYNC);
	assign s1_is_last = slot_s1 == spts_pkg::SLOT_W'(spts_pkg::LAST_SLOT);
	assign s1_is_chan = !s1_is_sync && !s1_is_last;

	assign acc     = spts_pkg::ACC_W'(elapsed_q) + spts_pkg::ACC_W'(clamped);
	assign acc_sat = (acc > spts_pkg::ACC_W'(spts_pkg::SUM_MAX))
		? spts_pkg::SUM_MAX : acc[spts_pkg::SUM_W-1:0];
	assign remainder = (frame_length_q > elapsed_q) ? frame_length_q - elapsed_q : '0;

	always_comb begin
		store_wr.en   = 1'b0;
		store_wr.addr = rd_ch_s1;
		store_wr.data = clamped;
		if (valid_s1) begin
			if (cmd_s1 == spts_pkg::CMD_SET) begin
				store_wr.en   = set_ok_s1;
				store_wr.addr = set_ch_s1;
				store_wr.data = set_val;
			end else begin
				store_wr.en = s1_is_chan;
			end
		end
	end

	always_comb begin
		sync_next = sync_q;
		if (s1_is_sync && !sync_disable_q) begin
			sync_next = 1'b1;
		end else if (slot_s1 == spts_pkg::SLOT_W'(spts_pkg::SLOT_SYNC_DROP)) begin
			sync_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q    <= 1'b0;
			elapsed_q <= '0;
		end else if (s1_tick) begin
			sync_q <= sync_next;
			if (s1_is_last) begin
				elapsed_q <= '0;
			end else if (s1_is_chan) begin
				elapsed_q <= acc_sat;
			end
		end
	end

	always_comb begin
		if (s1_is_sync) begin
			res.reload_count = spts_pkg::SUM_W'(pulse_center_q);
		end else if (s1_is_last) begin
			res.reload_count = remainder;
		end else begin
			res.reload_count = spts_pkg::SUM_W'(clamped);
		end
		res.sync_level = sync_next;
		res.slot       = spts_pkg::SLOT_FIELD_W'(slot_s1);
		res.frame_end  = s1_is_last;
	end

	assign push = s1_tick;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + spts_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + spts_pkg::FIFO_AW'(1);
			end
			cnt_q <= cnt_q + spts_pkg::FIFO_CW'(push) - spts_pkg::FIFO_CW'(pop);
		end
	end

	assign head = fifo_q[rd_ptr_q];

	assign request.ready = ({1'b0, cnt_q} + (spts_pkg::FIFO_CW+1)'(s1_tick))
		< (spts_pkg::FIFO_CW+1)'(spts_pkg::FIFO_DEPTH);

	assign result.valid        = cnt_q != '0;
	assign result.reload_count = head.reload_count;
	assign result.sync_level   = head.sync_level;
	assign result.slot         = head.slot;
	assign result.frame_end    = head.frame_end;

endmodule
